@@ sv/pam_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel to ASCII cell mapper package
// Shared constants, glyph codes and lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pam_pkg;

  localparam int RampLevels = 12;

  localparam logic [1:0] CFG_RETRO  = 2'd0;
  localparam logic [1:0] CFG_SINGLE = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  localparam logic [9:0] ThreshReset = 10'd1020;

  localparam logic [6:0] GLYPH_VBAR   = 7'h7C;
  localparam logic [6:0] GLYPH_UNDER  = 7'h5F;
  localparam logic [6:0] GLYPH_BSLASH = 7'h5C;
  localparam logic [6:0] GLYPH_SLASH  = 7'h2F;

  function automatic logic [6:0] ramp_char(input logic [3:0] idx);
    logic [6:0] c;
    case (idx)
      4'd0:    c = 7'h20;
      4'd1:    c = 7'h2E;
      4'd2:    c = 7'h2D;
      4'd3:    c = 7'h3D;
      4'd4:    c = 7'h2B;
      4'd5:    c = 7'h2A;
      4'd6:    c = 7'h78;
      4'd7:    c = 7'h23;
      4'd8:    c = 7'h24;
      4'd9:    c = 7'h26;
      4'd10:   c = 7'h58;
      default: c = 7'h40;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] hue_rgb(input logic [2:0] sector);
    logic [23:0] c;
    case (sector)
      3'd0:    c = 24'hFF0000;
      3'd1:    c = 24'hFFFF00;
      3'd2:    c = 24'h00FF00;
      3'd3:    c = 24'h00FFFF;
      3'd4:    c = 24'h0000FF;
      default: c = 24'hFF00FF;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  mx;
    logic [10:0] ax;
    logic [10:0] ay;
    logic        same_sign;
    logic [2:0]  sector;
    logic        white;
    logic        blk;
  } s1_t;

  typedef struct packed {
    logic [7:0]  r;
    logic [15:0] mx2;
    logic [21:0] ax2;
    logic [21:0] ay2;
    logic [23:0] ss;
    logic [19:0] th2;
    logic        zero_grad;
    logic        same_sign;
    logic [2:0]  sector;
    logic        white;
    logic        blk;
  } s2_t;

  typedef struct packed {
    logic [7:0] r;
    logic [6:0] glyph;
    logic       edge_hit;
    logic [2:0] sector;
    logic       white;
    logic       blk;
  } s3_t;

endpackage

`default_nettype wire

@@ sv/pam_in_if.sv @@
// ----------------------------------------------------------------------------
// Pixel request channel
// Carries one pixel and its Sobel gradients with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pam_in_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  red;
  logic        [7:0]  green;
  logic        [7:0]  blue;
  logic signed [10:0] grad_x;
  logic signed [10:0] grad_y;

  modport source (output valid, red, green, blue, grad_x, grad_y, input ready);
  modport sink (input valid, red, green, blue, grad_x, grad_y, output ready);
endinterface

`default_nettype wire

@@ sv/pam_out_if.sv @@
// ----------------------------------------------------------------------------
// Cell request channel
// Carries one ASCII cell, its color and the edge flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pam_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] glyph;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       is_edge;

  modport source (output valid, glyph, out_red, out_green, out_blue, is_edge,
                  input ready);
  modport sink (input valid, glyph, out_red, out_green, out_blue, is_edge,
                output ready);
endinterface

`default_nettype wire

@@ sv/pam_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined channel divider
// Four-stage restoring divider, two quotient bits per stage, for a 16-bit
// numerator whose quotient by the 8-bit divisor is known to fit in 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic      [7:0]  quo_o
);

  logic [15:0] rem_q [4];
  logic [7:0]  den_q [4];
  logic [7:0]  quo_q [4];

  for (genvar j = 0; j < 4; j++) begin : g_stage
    logic [15:0] rem_in;
    logic [7:0]  den_in;
    logic [7:0]  quo_in;
    logic [15:0] rem_d;
    logic [7:0]  quo_d;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      logic [15:0] trial;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int b = 0; b < 2; b++) begin
        trial = {8'd0, den_in} << (7 - 2 * j - b);
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          quo_d[7-2*j-b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_in;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[3];

endmodule

`default_nettype wire

@@ sv/pixel_to_ascii_cell_mapper.sv @@
// ----------------------------------------------------------------------------
// Pixel to ASCII cell mapper
// Turns one RGB pixel with its Sobel gradients into one colored ASCII cell.
// ----------------------------------------------------------------------------
// The block takes one pixel per cycle unless the output stalls and returns
// one cell per pixel, in order. The depth is set by the channel rescale,
// a four-stage divider behind one stage of range and hue logic; squares and
// compares for the ramp and edge test run beside it. The whole pipeline
// advances whenever the output register is empty or being taken, so a stall
// at the output holds every stage. Configuration is written through a plain
// write port and should only change while no pixel is in flight.
`default_nettype none

module pixel_to_ascii_cell_mapper (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  pam_in_if.sink          pix_i,
  pam_out_if.source       cell_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [9:0] cfg_data_i
);

  logic       retro_q;
  logic       single_q;
  logic [9:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retro_q  <= 1'b0;
      single_q <= 1'b0;
      thr_q    <= pam_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pam_pkg::CFG_RETRO:  retro_q  <= cfg_data_i[0];
        pam_pkg::CFG_SINGLE: single_q <= cfg_data_i[0];
        pam_pkg::CFG_THRESH: thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [5:1] v_q;
  logic       en;

  assign en          = !v_q[5] || cell_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:1], pix_i.valid};
    end
  end

  pam_pkg::s1_t s1_d, s1_q;
  logic [15:0]  num_r, num_g, num_b;

  always_comb begin
    logic [7:0]         mx, mn, chroma;
    logic signed [8:0]  d;
    logic signed [10:0] t, c2;
    logic [3:0]         base, k;
    mx = pix_i.red;
    mn = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;
    chroma = mx - mn;
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      d    = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
      base = d[8] ? 4'd6 : 4'd0;
    end else if (pix_i.green >= pix_i.blue) begin
      d    = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
      base = 4'd2;
    end else begin
      d    = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
      base = 4'd4;
    end
    t  = (11'(d) <<< 1) + $signed({3'b000, chroma});
    c2 = $signed({2'b00, chroma, 1'b0});
    if (t < 0) k = base - 4'd1;
    else if (t >= c2) k = base + 4'd1;
    else k = base;
    if (k == 4'd6) k = 4'd0;

    s1_d.r         = pix_i.red;
    s1_d.mx        = mx;
    s1_d.ax        = pix_i.grad_x[10] ? 11'(-pix_i.grad_x) : pix_i.grad_x;
    s1_d.ay        = pix_i.grad_y[10] ? 11'(-pix_i.grad_y) : pix_i.grad_y;
    s1_d.same_sign = (pix_i.grad_x > 0) == (pix_i.grad_y > 0);
    s1_d.sector    = k[2:0];
    s1_d.white     = {chroma, 2'b00} < {2'b00, mx};
    s1_d.blk       = mx == 8'd0;

    num_r = {pix_i.red, 8'd0} - {8'd0, pix_i.red};
    num_g = {pix_i.green, 8'd0} - {8'd0, pix_i.green};
    num_b = {pix_i.blue, 8'd0} - {8'd0, pix_i.blue};
  end

  logic [7:0] mx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  assign mx_q = s1_q.mx;

  logic [15:0] num_r_q, num_g_q, num_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_r_q <= num_r;
      num_g_q <= num_g;
      num_b_q <= num_b;
    end
  end

  logic [7:0] quo_r, quo_g, quo_b;

  pam_div u_div_r (.clk_i, .en_i(en), .num_i(num_r_q), .den_i(mx_q), .quo_o(quo_r));
  pam_div u_div_g (.clk_i, .en_i(en), .num_i(num_g_q), .den_i(mx_q), .quo_o(quo_g));
  pam_div u_div_b (.clk_i, .en_i(en), .num_i(num_b_q), .den_i(mx_q), .quo_o(quo_b));

  pam_pkg::s2_t s2_d, s2_q;

  always_comb begin
    logic [11:0] sum;
    sum            = {1'b0, s1_q.ax} + {1'b0, s1_q.ay};
    s2_d.r         = s1_q.r;
    s2_d.mx2       = s1_q.mx * s1_q.mx;
    s2_d.ax2       = s1_q.ax * s1_q.ax;
    s2_d.ay2       = s1_q.ay * s1_q.ay;
    s2_d.ss        = sum * sum;
    s2_d.th2       = thr_q * thr_q;
    s2_d.zero_grad = s1_q.ax == 11'd0 && s1_q.ay == 11'd0;
    s2_d.same_sign = s1_q.same_sign;
    s2_d.sector    = s1_q.sector;
    s2_d.white     = s1_q.white;
    s2_d.blk       = s1_q.blk;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
    end
  end

  pam_pkg::s3_t s3_d, s3_q, s4_q, s5_q;

  always_comb begin
    logic [19:0] m12;
    logic [11:0] r12;
    logic [3:0]  idx;
    logic [22:0] mag;
    logic [6:0]  eg;
    m12 = 20'(s2_q.mx2) * 20'd12;
    r12 = 12'(s2_q.r) * 12'd12;
    idx = '0;
    for (int k = 1; k < pam_pkg::RampLevels; k++) begin
      if (single_q ? (r12 >= 12'(k * 255)) : (m12 >= 20'(k * 65025))) begin
        idx = idx + 4'd1;
      end
    end
    mag = 23'(s2_q.ax2) + 23'(s2_q.ay2);
    if (s2_q.zero_grad) eg = pam_pkg::GLYPH_VBAR;
    else if (25'(s2_q.ss) < {2'b00, s2_q.ax2, 1'b0}) eg = pam_pkg::GLYPH_VBAR;
    else if (25'(s2_q.ss) < {2'b00, s2_q.ay2, 1'b0}) eg = pam_pkg::GLYPH_UNDER;
    else if (s2_q.same_sign) eg = pam_pkg::GLYPH_BSLASH;
    else eg = pam_pkg::GLYPH_SLASH;

    s3_d.r        = s2_q.r;
    s3_d.edge_hit = mag >= 23'(s2_q.th2);
    s3_d.glyph    = s3_d.edge_hit ? eg : pam_pkg::ramp_char(idx);
    s3_d.sector   = s2_q.sector;
    s3_d.white    = s2_q.white;
    s3_d.blk      = s2_q.blk;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
      s4_q <= s3_q;
      s5_q <= s4_q;
    end
  end

  logic [23:0] color;

  always_comb begin
    if (single_q) color = {s5_q.r, s5_q.r, s5_q.r};
    else if (s5_q.blk) color = 24'hFFFFFF;
    else if (!retro_q) color = {quo_r, quo_g, quo_b};
    else if (s5_q.white) color = 24'hFFFFFF;
    else color = pam_pkg::hue_rgb(s5_q.sector);
  end

  assign cell_o.valid     = v_q[5];
  assign cell_o.glyph     = s5_q.glyph;
  assign cell_o.out_red   = color[23:16];
  assign cell_o.out_green = color[15:8];
  assign cell_o.out_blue  = color[7:0];
  assign cell_o.is_edge   = s5_q.edge_hit;

`ifndef SYNTH
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready == (!cell_o.valid || cell_o.ready))
    else $error("input ready does not follow the output register");

  a_edge_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid && cell_o.is_edge |->
      (cell_o.glyph == pam_pkg::GLYPH_VBAR || cell_o.glyph == pam_pkg::GLYPH_UNDER ||
       cell_o.glyph == pam_pkg::GLYPH_BSLASH || cell_o.glyph == pam_pkg::GLYPH_SLASH))
    else $error("edge cell carries a ramp glyph");

  a_gray_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid && single_q |->
      cell_o.out_red == cell_o.out_green && cell_o.out_green == cell_o.out_blue)
    else $error("single-channel cell is not gray");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Pixel to ASCII cell mapper testbench
// Drives pixels through the request channel under random idling and stalls,
// predicts each cell from the pixel and the register settings, and compares
// every returned cell field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  typedef struct packed {
    logic [6:0] glyph;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       edge_flag;
  } cell_t;

  typedef struct packed {
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic               check_fixed;
    cell_t              fixed;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = pam_pkg::CFG_RETRO;
  logic [9:0] cfg_data_i = '0;

  pam_in_if pix_if ();
  pam_out_if cell_if ();

  pixel_to_ascii_cell_mapper u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_if.sink),
    .cell_o    (cell_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic       retro_q = 1'b0;
  logic       single_q = 1'b0;
  logic [9:0] thresh_q = pam_pkg::ThreshReset;

  cell_t expected_cells[$];
  int errors = 0;
  int cells_seen = 0;
  int edges_seen = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  function automatic logic [2:0] round_sector(int base, int d, int chroma);
    int t;
    int k;
    t = 2 * d + chroma;
    k = base;
    if (t < 0) k = k - 1;
    else if (t >= 2 * chroma) k = k + 1;
    k = k % 6;
    if (k < 0) k = k + 6;
    return 3'(k);
  endfunction

  function automatic cell_t predict_cell(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                                         logic signed [10:0] gx, logic signed [10:0] gy);
    cell_t c;
    int r, g, b, mx, mn, idx, chroma, ax, ay, s;
    logic [2:0] k;
    logic [23:0] hue;
    longint mag, th;
    r = int'(r8); g = int'(g8); b = int'(b8);
    if (single_q) begin
      idx = r * 12 / 255;
      c.r = r8; c.g = r8; c.b = r8;
    end else begin
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      idx = mx * mx * 12 / 65025;
      if (mx == 0) begin
        c.r = 8'd255; c.g = 8'd255; c.b = 8'd255;
      end else if (!retro_q) begin
        c.r = 8'(r * 255 / mx); c.g = 8'(g * 255 / mx); c.b = 8'(b * 255 / mx);
      end else begin
        chroma = mx - mn;
        if (4 * chroma < mx) begin
          c.r = 8'd255; c.g = 8'd255; c.b = 8'd255;
        end else begin
          if (r >= g && r >= b) k = round_sector((g - b) >= 0 ? 0 : 6, g - b, chroma);
          else if (g >= b) k = round_sector(2, b - r, chroma);
          else k = round_sector(4, r - g, chroma);
          hue = pam_pkg::hue_rgb(k);
          {c.r, c.g, c.b} = hue;
        end
      end
    end
    if (idx > 11) idx = 11;
    c.glyph = pam_pkg::ramp_char(4'(idx));
    c.edge_flag = 1'b0;
    mag = longint'(gx) * longint'(gx) + longint'(gy) * longint'(gy);
    th = longint'(thresh_q);
    if (mag >= th * th) begin
      c.edge_flag = 1'b1;
      ax = gx < 0 ? -int'(gx) : int'(gx);
      ay = gy < 0 ? -int'(gy) : int'(gy);
      s = (ax + ay) * (ax + ay);
      if (ax == 0 && ay == 0) c.glyph = pam_pkg::GLYPH_VBAR;
      else if (s < 2 * ax * ax) c.glyph = pam_pkg::GLYPH_VBAR;
      else if (s < 2 * ay * ay) c.glyph = pam_pkg::GLYPH_UNDER;
      else if ((gx > 0) == (gy > 0)) c.glyph = pam_pkg::GLYPH_BSLASH;
      else c.glyph = pam_pkg::GLYPH_SLASH;
    end
    return c;
  endfunction

  // Output side: random stalls and in-order comparison.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("%0t timeout", $time);
      $display("DONE: errors detected");
      $finish;
    end
    if (cell_if.valid && cell_if.ready) begin
      cell_t got;
      cell_t want;
      got = '{cell_if.glyph, cell_if.out_red, cell_if.out_green, cell_if.out_blue,
              cell_if.is_edge};
      cells_seen <= cells_seen + 1;
      if (got.edge_flag) edges_seen <= edges_seen + 1;
      if (expected_cells.size() == 0) begin
        $display("%0t unexpected cell: actual %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = expected_cells.pop_front();
        if (got !== want) begin
          $display("%0t cell mismatch: expected glyph %h rgb %h %h %h edge %b, actual glyph %h rgb %h %h %h edge %b",
                   $time, want.glyph, want.r, want.g, want.b, want.edge_flag,
                   got.glyph, got.r, got.g, got.b, got.edge_flag);
          errors <= errors + 1;
        end
      end
    end
    if (calm) begin
      cell_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      cell_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      cell_if.ready <= 1'b0;
    end else begin
      cell_if.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      pam_pkg::CFG_RETRO:  retro_q = val[0];
      pam_pkg::CFG_SINGLE: single_q = val[0];
      default:             thresh_q = val;
    endcase
  endtask

  task automatic drain();
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_pixel(pixel_row_t p, bit allow_gap);
    cell_t c;
    if (allow_gap && !calm && $urandom_range(0, 5) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    c = predict_cell(p.r, p.g, p.b, p.gx, p.gy);
    if (p.check_fixed && c !== p.fixed) begin
      $display("%0t directed row disagrees: expected %h, predicted %h", $time, p.fixed, c);
      errors++;
    end
    pix_if.valid <= 1'b1;
    pix_if.red <= p.r;
    pix_if.green <= p.g;
    pix_if.blue <= p.b;
    pix_if.grad_x <= p.gx;
    pix_if.grad_y <= p.gy;
    expected_cells.push_back(c);
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
  endtask

  task automatic random_pixel(output pixel_row_t p);
    int mode;
    p = '0;
    mode = $urandom_range(0, 3);
    p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
    if (mode == 0) begin
      p.gx = 11'($urandom_range(0, 2040)) - 11'sd1020;
      p.gy = 11'($urandom_range(0, 2040)) - 11'sd1020;
    end else if (mode == 1) begin
      p.gx = 11'($urandom);
      p.gy = 11'($urandom);
    end else begin
      p.gx = 11'($urandom_range(0, 80)) - 11'sd40;
      p.gy = 11'($urandom_range(0, 80)) - 11'sd40;
      if (mode == 3) begin
        p.g = p.r - 8'($urandom_range(0, 12));
        p.b = p.r - 8'($urandom_range(0, 12));
      end
    end
  endtask

  pixel_row_t directed_rows[] = '{
    '{8'd0, 8'd0, 8'd0, 11'sd0, 11'sd0, 1'b1, '{7'h20, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{8'd255, 8'd255, 8'd255, 11'sd0, 11'sd0, 1'b1, '{7'h40, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{8'd255, 8'd0, 8'd0, 11'sd1020, 11'sd0, 1'b1,
      '{pam_pkg::GLYPH_VBAR, 8'd255, 8'd0, 8'd0, 1'b1}},
    '{8'd0, 8'd255, 8'd0, 11'sd0, -11'sd1020, 1'b1,
      '{pam_pkg::GLYPH_UNDER, 8'd0, 8'd255, 8'd0, 1'b1}},
    '{8'd0, 8'd0, 8'd255, 11'sd800, 11'sd800, 1'b1,
      '{pam_pkg::GLYPH_BSLASH, 8'd0, 8'd0, 8'd255, 1'b1}},
    '{8'd0, 8'd0, 8'd128, -11'sd800, 11'sd800, 1'b0, '0},
    '{8'd100, 8'd50, 8'd25, -11'sd1020, -11'sd1020, 1'b0, '0},
    '{8'd1, 8'd0, 8'd0, 11'sd1023, -11'sd1024, 1'b0, '0},
    '{8'd200, 8'd200, 8'd10, 11'sd1, 11'sd0, 1'b0, '0},
    '{8'd10, 8'd200, 8'd200, 11'sd0, 11'sd1, 1'b0, '0},
    '{8'd200, 8'd10, 8'd200, -11'sd1, -11'sd1, 1'b0, '0},
    '{8'd200, 8'd190, 8'd180, 11'sd5, -11'sd3, 1'b0, '0},
    '{8'd200, 8'd150, 8'd100, 11'sd3, 11'sd7, 1'b0, '0},
    '{8'd100, 8'd200, 8'd150, -11'sd1024, 11'sd1023, 1'b0, '0},
    '{8'd170, 8'd85, 8'd255, 11'sd400, 11'sd10, 1'b0, '0},
    '{8'd21, 8'd22, 8'd43, 11'sd10, 11'sd400, 1'b0, '0}
  };

  initial begin
    pixel_row_t p;
    int settings[6][3] = '{'{0, 0, 1020}, '{1, 0, 0}, '{0, 1, 1023},
                           '{1, 1, 300}, '{1, 0, 1}, '{0, 0, 600}};
    pix_if.valid = 1'b0;
    pix_if.red = '0; pix_if.green = '0; pix_if.blue = '0;
    pix_if.grad_x = '0; pix_if.grad_y = '0;
    cell_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_pixel(directed_rows[i], 1'b1);
    pix_if.valid <= 1'b0;
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(pam_pkg::CFG_RETRO, 10'(settings[ph][0]));
      write_reg(pam_pkg::CFG_SINGLE, 10'(settings[ph][1]));
      write_reg(pam_pkg::CFG_THRESH, 10'(settings[ph][2]));
      cfg_we_i <= 1'b0;
      if (ph == 1 || ph == 2) begin
        foreach (directed_rows[i]) begin
          p = directed_rows[i];
          p.check_fixed = 1'b0;
          send_pixel(p, 1'b1);
        end
      end
      if (ph == 5) calm = 1'b1;
      for (int n = 0; n < 90; n++) begin
        random_pixel(p);
        send_pixel(p, 1'b1);
        if (ph == 3 && n == 40) begin
          pix_if.valid <= 1'b0;
          while (expected_cells.size() != 0) @(posedge clk_i);
        end
      end
      pix_if.valid <= 1'b0;
      drain();
    end
    $display("Checked %0d cells (%0d edge glyphs) over six register settings,",
             cells_seen, edges_seen);
    $display("covering gray, retro and normal color with thresholds from 0 to 1023.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/pam_pkg.sv
sv/pam_in_if.sv
sv/pam_out_if.sv
sv/pam_div.sv
sv/pixel_to_ascii_cell_mapper.sv
bench/tb_top.sv
